// ===== hw/rtl/nae_pkg.sv =====
// nae_pkg: shared types, constants and controller commands of the nnue evaluator
// no dependencies
package nae_pkg;
	localparam int NumFeatures = 45056;
	localparam int HiddenUnits = 256;
	localparam int ClipMax = 255;
	localparam int QuantOut = 64;
	localparam int ScoreScale = 400;
	localparam int ScoreDiv = ClipMax * QuantOut;

	typedef enum logic [2:0] {
		MODE_WR_IN = 3'd0,
		MODE_WR_BIAS = 3'd1,
		MODE_WR_OUT = 3'd2,
		MODE_CLEAR = 3'd3,
		MODE_LOAD = 3'd4,
		MODE_ADD = 3'd5,
		MODE_SUB = 3'd6,
		MODE_EVAL = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_ROW_RD,
		ST_ROW_WAIT,
		ST_ROW_WB,
		ST_EVAL_RD,
		ST_EVAL_WAIT,
		ST_EVAL_MAC,
		ST_SCALE,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic do_write;
		logic row_rd;
		logic row_wb;
		logic eval_rd;
		logic eval_mac;
		logic eval_clr;
		logic scale;
		logic div_start;
		logic div_step;
		logic load_item;
		logic step_lane;
		logic clr_lane;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic lane_last;
		logic div_done;
		logic init_done;
	} stat_t;
endpackage

// ===== hw/rtl/nae_if.sv =====
// nae_if: valid/ready request channel with a payload of parametric type
// depends on nothing
interface nae_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/nnue_accumulator_evaluator_core.sv =====
// nnue_accumulator_evaluator_core: top level of the nnue evaluator
// depends on nae_pkg, nae_if, nae_ctrl, nae_dp
// After reset a sweep clears the accumulators; no request is taken then. Weight writes
// pass through the write state; out-of-range requests are taken in idle and dropped.
// Clear, load, add and remove walk the lanes through the single accumulator ram port,
// each lane in a read, a wait and a write-back state. Evaluate walks both accumulators
// the same way, with a mac state in place of the write-back, then scales and divides by
// a reciprocal before the score is offered.
module nnue_accumulator_evaluator_core #(
	parameter int NUM_FEATURES = nae_pkg::NumFeatures,
	parameter int HIDDEN_UNITS = nae_pkg::HiddenUnits
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	nae_if.sink in_ch,
	nae_if.source out_ch
);
	logic signed [15:0] bias_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bias_q <= '0;
		else if (cfg_we) bias_q <= cfg_wdata;
	end

	nae_pkg::cmd_t cmd;
	nae_pkg::stat_t stat;
	logic skip;

	nae_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_mode(in_ch.data.mode),
		.in_skip(skip), .out_ready(out_ch.ready), .stat(stat), .in_ready(in_ch.ready),
		.cmd(cmd)
	);

	nae_dp #(.NumFeatures(NUM_FEATURES), .HiddenUnits(HIDDEN_UNITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .mode(in_ch.data.mode), .side(in_ch.data.side),
		.feature_index(in_ch.data.feature_index), .slot(in_ch.data.slot),
		.weight_value(in_ch.data.weight_value), .output_bias(bias_q), .cmd(cmd),
		.skip(skip), .stat(stat), .score(out_ch.data.score)
	);

	assign out_ch.valid = cmd.out_valid;
endmodule

// ===== hw/rtl/nae_ram.sv =====
// nae_ram: generic single port ram with registered read
// no dependencies
module nae_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input logic clk,
	input logic we,
	input logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== hw/rtl/nae_ctrl.sv =====
// nae_ctrl: sequencer of the nnue evaluator
// depends on nae_pkg
module nae_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [2:0] in_mode,
	input logic in_skip,
	input logic out_ready,
	input nae_pkg::stat_t stat,
	output logic in_ready,
	output nae_pkg::cmd_t cmd
);
	nae_pkg::state_t state_q, state_d;
	logic [2:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nae_pkg::ST_INIT;
			mode_q <= nae_pkg::MODE_WR_IN;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				mode_q <= in_mode;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nae_pkg::ST_INIT: if (stat.init_done) state_d = nae_pkg::ST_IDLE;
			nae_pkg::ST_IDLE: begin
				if (in_valid) begin
					priority if (in_skip) state_d = nae_pkg::ST_IDLE;
					else if (in_mode == nae_pkg::MODE_EVAL) state_d = nae_pkg::ST_EVAL_RD;
					else if (in_mode == nae_pkg::MODE_CLEAR || in_mode == nae_pkg::MODE_LOAD
						|| in_mode == nae_pkg::MODE_ADD || in_mode == nae_pkg::MODE_SUB)
						state_d = nae_pkg::ST_ROW_RD;
					else state_d = nae_pkg::ST_WRITE;
				end
			end
			nae_pkg::ST_WRITE: state_d = nae_pkg::ST_IDLE;
			nae_pkg::ST_ROW_RD: state_d = nae_pkg::ST_ROW_WAIT;
			nae_pkg::ST_ROW_WAIT: state_d = nae_pkg::ST_ROW_WB;
			nae_pkg::ST_ROW_WB: state_d = stat.lane_last ? nae_pkg::ST_IDLE : nae_pkg::ST_ROW_RD;
			nae_pkg::ST_EVAL_RD: state_d = nae_pkg::ST_EVAL_WAIT;
			nae_pkg::ST_EVAL_WAIT: state_d = nae_pkg::ST_EVAL_MAC;
			nae_pkg::ST_EVAL_MAC: state_d = stat.lane_last ? nae_pkg::ST_SCALE
				: nae_pkg::ST_EVAL_RD;
			nae_pkg::ST_SCALE: state_d = nae_pkg::ST_DIV;
			nae_pkg::ST_DIV: if (stat.div_done) state_d = nae_pkg::ST_OUT;
			nae_pkg::ST_OUT: if (out_ready) state_d = nae_pkg::ST_IDLE;
			default: state_d = nae_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			nae_pkg::ST_INIT: cmd.init_wr = 1'b1;
			nae_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
				cmd.clr_lane = 1'b1;
				cmd.eval_clr = 1'b1;
			end
			nae_pkg::ST_WRITE: cmd.do_write = 1'b1;
			nae_pkg::ST_ROW_RD: cmd.row_rd = 1'b1;
			nae_pkg::ST_ROW_WAIT: ;
			nae_pkg::ST_ROW_WB: begin
				cmd.row_wb = 1'b1;
				cmd.step_lane = 1'b1;
			end
			nae_pkg::ST_EVAL_RD: cmd.eval_rd = 1'b1;
			nae_pkg::ST_EVAL_WAIT: ;
			nae_pkg::ST_EVAL_MAC: begin
				cmd.eval_mac = 1'b1;
				cmd.step_lane = 1'b1;
			end
			nae_pkg::ST_SCALE: cmd.scale = 1'b1;
			nae_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_start = 1'b0;
			end
			nae_pkg::ST_OUT: cmd.out_valid = 1'b1;
			default: ;
		endcase
		if (mode_q == nae_pkg::MODE_EVAL && state_q == nae_pkg::ST_SCALE) begin
			cmd.div_start = 1'b1;
		end
	end
endmodule

// ===== hw/rtl/nae_dp.sv =====
// nae_dp: datapath of the nnue evaluator, weight stores, accumulators, mac and divider
// depends on nae_pkg and nae_ram
module nae_dp #(
	parameter int NumFeatures = nae_pkg::NumFeatures,
	parameter int HiddenUnits = nae_pkg::HiddenUnits
) (
	input logic clk,
	input logic arst_n,
	input logic [2:0] mode,
	input logic side,
	input logic [15:0] feature_index,
	input logic [8:0] slot,
	input logic signed [15:0] weight_value,
	input logic signed [15:0] output_bias,
	input nae_pkg::cmd_t cmd,
	output logic skip,
	output nae_pkg::stat_t stat,
	output logic signed [18:0] score
);
	localparam int LaneW = (HiddenUnits > 1) ? $clog2(HiddenUnits) : 1;
	localparam int FeatW = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;
	localparam int InDepth = NumFeatures * HiddenUnits;
	localparam int InW = $clog2(InDepth) > 0 ? $clog2(InDepth) : 1;
	localparam int AccW = $clog2(2 * HiddenUnits);
	localparam int OutW = $clog2(2 * HiddenUnits);
	localparam int DivShift = $clog2(nae_pkg::QuantOut);
	localparam int RecipShift = 34;
	localparam logic [26:0] Recip = 27'(((64'd1 << RecipShift) + 64'(nae_pkg::ClipMax)
		- 64'd1) / 64'(nae_pkg::ClipMax));

	logic [2:0] mode_q;
	logic side_q;
	logic [FeatW-1:0] feat_q;
	logic [8:0] slot_q;
	logic [15:0] val_q;
	logic [LaneW:0] lane_q;
	logic [LaneW:0] init_q;
	logic [1:0] ev_half_q;

	logic feat_ok, slot_h_ok, slot_o_ok;
	assign feat_ok = {16'd0, feature_index} < 32'(NumFeatures);
	assign slot_h_ok = {23'd0, slot} < 32'(HiddenUnits);
	assign slot_o_ok = {23'd0, slot} < 32'(2 * HiddenUnits);

	always_comb begin
		unique case (mode)
			nae_pkg::MODE_WR_IN: skip = !(feat_ok && slot_h_ok);
			nae_pkg::MODE_WR_BIAS: skip = !slot_h_ok;
			nae_pkg::MODE_WR_OUT: skip = !slot_o_ok;
			nae_pkg::MODE_ADD, nae_pkg::MODE_SUB: skip = !feat_ok;
			default: skip = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode;
			side_q <= side;
			feat_q <= feature_index[FeatW-1:0];
			slot_q <= slot;
			val_q <= weight_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			init_q <= '0;
			ev_half_q <= '0;
		end else begin
			if (cmd.init_wr) init_q <= init_q + 1'b1;
			if (cmd.clr_lane) begin
				lane_q <= '0;
				ev_half_q <= '0;
			end else if (cmd.step_lane) begin
				if (mode_q == nae_pkg::MODE_EVAL && ev_half_q == 2'd0
					&& lane_q[LaneW-1:0] == LaneW'(HiddenUnits - 1)) begin
					lane_q <= '0;
					ev_half_q <= 2'd1;
				end else begin
					lane_q <= lane_q + 1'b1;
				end
			end
		end
	end
	assign stat.init_done = init_q == (LaneW + 1)'(2 * HiddenUnits - 1);
	assign stat.lane_last = lane_q[LaneW-1:0] == LaneW'(HiddenUnits - 1)
		&& (mode_q != nae_pkg::MODE_EVAL || ev_half_q == 2'd1);

	logic [LaneW-1:0] lane;
	assign lane = lane_q[LaneW-1:0];

	// input weights
	logic in_we;
	logic [InW-1:0] in_addr;
	logic [15:0] in_rd;
	assign in_we = cmd.do_write && mode_q == nae_pkg::MODE_WR_IN;
	assign in_addr = in_we ? InW'(32'(feat_q) * 32'(HiddenUnits) + 32'(slot_q))
		: InW'(32'(feat_q) * 32'(HiddenUnits) + 32'(lane));
	nae_ram #(.Width(16), .Depth(InDepth)) u_in (
		.clk(clk), .we(in_we), .addr(in_addr), .wdata(val_q), .rdata(in_rd)
	);

	// hidden biases
	logic hb_we;
	logic [LaneW-1:0] hb_addr;
	logic [15:0] hb_rd;
	assign hb_we = cmd.do_write && mode_q == nae_pkg::MODE_WR_BIAS;
	assign hb_addr = hb_we ? slot_q[LaneW-1:0] : lane;
	nae_ram #(.Width(16), .Depth(HiddenUnits)) u_hb (
		.clk(clk), .we(hb_we), .addr(hb_addr), .wdata(val_q), .rdata(hb_rd)
	);

	// output weights
	logic ow_we;
	logic [OutW-1:0] ow_addr;
	logic [15:0] ow_rd;
	assign ow_we = cmd.do_write && mode_q == nae_pkg::MODE_WR_OUT;
	assign ow_addr = ow_we ? slot_q[OutW-1:0]
		: (ev_half_q[0] ? OutW'(HiddenUnits) + OutW'(lane) : OutW'(lane));
	nae_ram #(.Width(16), .Depth(2 * HiddenUnits)) u_ow (
		.clk(clk), .we(ow_we), .addr(ow_addr), .wdata(val_q), .rdata(ow_rd)
	);

	// accumulators, cleared by a sweep after reset
	logic acc_we;
	logic [AccW-1:0] acc_addr;
	logic [15:0] acc_wd, acc_rd, row_res;
	logic acc_side;
	assign acc_side = (mode_q == nae_pkg::MODE_EVAL) ? (side_q ^ ev_half_q[0]) : side_q;
	always_comb begin
		unique case (mode_q)
			nae_pkg::MODE_CLEAR: row_res = '0;
			nae_pkg::MODE_LOAD: row_res = hb_rd;
			nae_pkg::MODE_SUB: row_res = acc_rd - in_rd;
			default: row_res = acc_rd + in_rd;
		endcase
	end
	assign acc_we = cmd.init_wr || cmd.row_wb;
	assign acc_wd = cmd.init_wr ? 16'd0 : row_res;
	assign acc_addr = cmd.init_wr ? init_q[AccW-1:0]
		: (acc_side ? AccW'(HiddenUnits) + AccW'(lane) : AccW'(lane));
	nae_ram #(.Width(16), .Depth(2 * HiddenUnits)) u_acc (
		.clk(clk), .we(acc_we), .addr(acc_addr), .wdata(acc_wd), .rdata(acc_rd)
	);

	// mac
	logic [7:0] clip;
	logic [31:0] sum_q;
	logic signed [24:0] prod;
	always_comb begin
		priority if (acc_rd[15]) clip = 8'd0;
		else if (acc_rd > 16'(nae_pkg::ClipMax)) clip = 8'(nae_pkg::ClipMax);
		else clip = acc_rd[7:0];
	end
	assign prod = $signed({1'b0, clip}) * $signed(ow_rd);

	// scale and divide: shift out the quant factor, then multiply by a reciprocal of clip max
	logic [31:0] quo_q;
	logic done_q;
	logic neg_q;
	logic [31:0] scaled;
	logic [52:0] recip_prod;
	assign scaled = (sum_q + 32'($signed(output_bias))) * 32'(nae_pkg::ScoreScale);
	assign recip_prod = 53'(quo_q[31:DivShift]) * 53'(Recip);

	always_ff @(posedge clk) begin
		if (cmd.eval_clr) sum_q <= '0;
		else if (cmd.eval_mac) sum_q <= sum_q + 32'(prod);
		if (cmd.div_start) begin
			neg_q <= scaled[31];
			quo_q <= scaled[31] ? -scaled : scaled;
			done_q <= 1'b0;
		end else if (cmd.div_step && !done_q) begin
			quo_q <= 32'(recip_prod[52:RecipShift]);
			done_q <= 1'b1;
		end
	end
	assign stat.div_done = done_q;
	logic [31:0] sres;
	assign sres = neg_q ? -quo_q : quo_q;
	assign score = sres[18:0];
endmodule

// ===== verif/tb_nnue_accumulator_evaluator_core.sv =====
// tb_nnue_accumulator_evaluator_core: self-checking testbench of the nnue evaluator core
// needs nae_pkg, nae_if and the core; a scoreboard class predicts every evaluate score
`timescale 1ns / 1ps

module tb_nnue_accumulator_evaluator_core;
	import nae_pkg::*;

	localparam int HU = HiddenUnits;
	localparam int NF = NumFeatures;
	localparam int DRAIN_CYCLES = 6 * HU + 64;

	typedef struct packed {
		mode_t mode;
		logic side;
		logic [15:0] feature_index;
		logic [8:0] slot;
		logic signed [15:0] weight_value;
	} req_t;

	typedef struct packed {
		logic signed [18:0] score;
	} res_t;

	class score_board;
		bit [15:0] acc[2][HU];
		bit [15:0] in_w[int];
		bit [15:0] hbias[HU];
		bit [15:0] out_w[2 * HU];
		bit [15:0] out_bias;
		logic [18:0] scores[$];
		int errors;

		function new();
			errors = 0;
			out_bias = 0;
			foreach (acc[s, j]) acc[s][j] = 0;
		endfunction

		function int clip(bit [15:0] v);
			int x;
			x = $signed(v);
			if (x < 0) return 0;
			if (x > ClipMax) return ClipMax;
			return x;
		endfunction

		function logic [18:0] eval_score(bit stm);
			int sum;
			int q;
			sum = 0;
			for (int i = 0; i < HU; i++) begin
				sum += clip(acc[stm][i]) * int'($signed(out_w[i]));
				sum += clip(acc[!stm][i]) * int'($signed(out_w[HU + i]));
			end
			sum += int'($signed(out_bias));
			sum = sum * ScoreScale;
			q = sum / ScoreDiv;
			return q[18:0];
		endfunction

		function void note(req_t r);
			int f;
			f = r.feature_index;
			case (r.mode)
				MODE_WR_IN: if (f < NF && r.slot < HU) in_w[f * HU + r.slot] = r.weight_value;
				MODE_WR_BIAS: if (r.slot < HU) hbias[r.slot] = r.weight_value;
				MODE_WR_OUT: if (r.slot < 2 * HU) out_w[r.slot] = r.weight_value;
				MODE_CLEAR: for (int j = 0; j < HU; j++) acc[r.side][j] = 0;
				MODE_LOAD: for (int j = 0; j < HU; j++) acc[r.side][j] = hbias[j];
				MODE_ADD: if (f < NF) for (int j = 0; j < HU; j++)
					acc[r.side][j] = acc[r.side][j] + in_w[f * HU + j];
				MODE_SUB: if (f < NF) for (int j = 0; j < HU; j++)
					acc[r.side][j] = acc[r.side][j] - in_w[f * HU + j];
				default: scores.insert(scores.size(), eval_score(r.side));
			endcase
		endfunction

		function void check(logic [18:0] got);
			logic [18:0] want;
			if (scores.size() == 0) begin
				if (errors < 10) $display("unexpected score %0d", $signed(got));
				errors++;
			end else begin
				want = scores.pop_front();
				if (got !== want) begin
					if (errors < 10)
						$display("score mismatch: expected %0d got %0d", $signed(want), $signed(got));
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	int send_idle;
	int recv_stall;
	int full_rows[$];
	score_board sb;

	nae_if #(.payload_t(req_t)) in_ch ();
	nae_if #(.payload_t(res_t)) out_ch ();

	nnue_accumulator_evaluator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#20_000_000;
		$display("nnue_accumulator_evaluator_core test failed");
		$finish;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data.score);
	end

	function automatic req_t mk(mode_t m, bit s, int f, int sl, int v);
		req_t r;
		r.mode = m;
		r.side = s;
		r.feature_index = f[15:0];
		r.slot = sl[8:0];
		r.weight_value = v[15:0];
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send(req_t r);
		while ($urandom_range(0, 99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= r;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note(r);
		@(negedge clk);
	endtask

	task automatic write_bias(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.out_bias = v;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.scores.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int small_or_wide();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
		return $urandom_range(0, 220) - 20;
	endfunction

	function automatic req_t random_req();
		int pick;
		int f;
		pick = $urandom_range(0, 99);
		f = full_rows[$urandom_range(0, full_rows.size() - 1)];
		if (pick < 12) return mk(MODE_EVAL, $urandom_range(0, 1), $urandom_range(0, 65535),
			$urandom_range(0, 511), $urandom_range(0, 65535));
		if (pick < 37 || pick < 52) begin
			if ($urandom_range(0, 6) == 0) f = $urandom_range(NF, 65535);
			return mk(pick < 37 ? MODE_ADD : MODE_SUB, $urandom_range(0, 1), f,
				$urandom_range(0, 511), $urandom_range(0, 65535));
		end
		if (pick < 60) return mk(MODE_LOAD, $urandom_range(0, 1), $urandom_range(0, 65535),
			$urandom_range(0, 511), $urandom_range(0, 65535));
		if (pick < 65) return mk(MODE_CLEAR, $urandom_range(0, 1), $urandom_range(0, 65535),
			$urandom_range(0, 511), $urandom_range(0, 65535));
		if (pick < 80) begin
			// rewrite a full row, or write somewhere that is never read
			if ($urandom_range(0, 3) == 0) f = $urandom_range(0, 65535);
			return mk(MODE_WR_IN, $urandom_range(0, 1), f, $urandom_range(0, 511),
				small_or_wide());
		end
		if (pick < 90) return mk(MODE_WR_BIAS, $urandom_range(0, 1), $urandom_range(0, 65535),
			$urandom_range(0, 511), small_or_wide());
		return mk(MODE_WR_OUT, $urandom_range(0, 1), $urandom_range(0, 65535),
			$urandom_range(0, 511), $urandom_range(0, 65535));
	endfunction

	initial begin
		logic [15:0] biases[4];
		int idles[4][2];
		int v;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		send_idle = 0;
		recv_stall = 0;
		biases = '{16'h7fff, 16'h8000, 16'h0000, 16'h0000};
		biases[3] = $urandom_range(0, 65535);
		idles = '{'{0, 0}, '{85, 0}, '{0, 85}, '{38, 38}};
		full_rows = '{0, 1, 2, NF - 1, 0};
		full_rows[4] = $urandom_range(3, NF - 2);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_bias(biases[0]);

		// load every weight that is ever read
		for (int i = 0; i < 2 * HU; i++)
			send(mk(MODE_WR_OUT, 0, 0, i, $urandom_range(0, 65535)));
		for (int i = 0; i < HU; i++)
			send(mk(MODE_WR_BIAS, 1, 0, i, small_or_wide()));
		foreach (full_rows[k]) for (int j = 0; j < HU; j++) begin
			case (k)
				1: v = $urandom_range(0, 65535);
				2: v = 16'h8000;
				3: v = 16'h7fff;
				default: v = $urandom_range(0, 60) - 10;
			endcase
			send(mk(MODE_WR_IN, k[0], full_rows[k], j, v));
		end

		// directed corners
		send(mk(MODE_EVAL, 0, 0, 0, 0));
		send(mk(MODE_LOAD, 0, 0, 0, 0));
		send(mk(MODE_LOAD, 1, 65535, 511, 16'hffff));
		send(mk(MODE_EVAL, 1, 0, 0, 0));
		send(mk(MODE_ADD, 0, 0, 0, 0));
		send(mk(MODE_ADD, 0, NF, 0, 0));
		send(mk(MODE_SUB, 1, 65535, 0, 0));
		send(mk(MODE_ADD, 1, NF - 1, 0, 0));
		send(mk(MODE_ADD, 1, NF - 1, 0, 0));
		send(mk(MODE_SUB, 0, 2, 0, 0));
		send(mk(MODE_EVAL, 0, 0, 0, 0));
		send(mk(MODE_WR_IN, 0, 65535, 0, 16'h7fff));
		send(mk(MODE_WR_IN, 0, 0, 256, 16'h8000));
		send(mk(MODE_WR_BIAS, 0, 0, 511, 16'h8000));
		send(mk(MODE_WR_OUT, 0, 0, 511, 16'h8000));
		send(mk(MODE_WR_OUT, 0, 0, 0, 16'h7fff));
		send(mk(MODE_EVAL, 1, 0, 0, 0));
		send(mk(MODE_CLEAR, 0, 0, 0, 0));
		send(mk(MODE_EVAL, 0, 0, 0, 0));
		send(mk(MODE_CLEAR, 1, 0, 0, 0));
		send(mk(MODE_EVAL, 1, 0, 0, 0));

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				drain();
				write_bias(biases[p]);
			end
			send_idle = idles[p][0];
			recv_stall = idles[p][1];
			for (int n = 0; n < 350; n++) send(random_req());
		end
		drain();
		write_bias(16'h0000);
		send(mk(MODE_EVAL, 0, 0, 0, 0));
		in_ch.valid <= 1'b0;

		while (sb.scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.scores.size() == 0) begin
			$display("nnue_accumulator_evaluator_core test passed");
		end else begin
			$display("nnue_accumulator_evaluator_core test failed");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/nae_pkg.sv
hw/rtl/nae_if.sv
hw/rtl/nae_ram.sv
hw/rtl/nae_ctrl.sv
hw/rtl/nae_dp.sv
hw/rtl/nnue_accumulator_evaluator_core.sv
verif/tb_nnue_accumulator_evaluator_core.sv
